[rtl/led_breathing_mode_controller_defines.svh]
// ---------------------------------------------------------------------------
// LED breathing mode controller: assertion macros
// Shared assertion wrappers. Define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef LED_BREATHING_MODE_CONTROLLER_DEFINES_SVH
`define LED_BREATHING_MODE_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define LBMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbmc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbmc assertion failed");

`else

`define LBMC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LBMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/lbmc_pkg.sv]
// ---------------------------------------------------------------------------
// LED breathing mode controller package
// State type, mode table and the small arithmetic helpers of the step logic.
// ---------------------------------------------------------------------------
package lbmc_pkg;

    // Mode numbers with a special meaning.
    localparam logic [3:0] MODE_FIRST   = 4'd1;
    localparam logic [3:0] MODE_FLICKER = 4'd4;
    localparam logic [3:0] MODE_LAST    = 4'd12;

    // Phases are in half units: 11 bits, always below PHASE_WRAP.
    localparam int unsigned PHASE_W = 11;
    localparam logic [PHASE_W-1:0] PHASE_WRAP = 11'd1020;
    localparam logic [PHASE_W-1:0] PHASE_HALF = 11'd510;

    localparam logic [9:0]  THRESH_RESET = 10'd20;
    localparam logic [15:0] LFSR_SEED    = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;

    // Per-mode phase step in half units, indexed by the mode number.
    localparam logic [8:0] MODE_STEP [16] = '{
        9'd0, 9'd1, 9'd2, 9'd4, 9'd0, 9'd1, 9'd1, 9'd40,
        9'd508, 9'd40, 9'd508, 9'd20, 9'd508, 9'd0, 9'd0, 9'd0
    };
    // Channel select per mode; bit n belongs to mode n.
    localparam logic [15:0] MODE_BLUE   = 16'b0001_1001_1010_1110;
    localparam logic [15:0] MODE_ORANGE = 16'b0001_1110_0100_1110;

    typedef struct packed {
        logic [3:0]         mode;
        logic               init_pending;
        logic [PHASE_W-1:0] blue_phase;
        logic [PHASE_W-1:0] orange_phase;
        logic [7:0]         blue_level;
        logic [7:0]         orange_level;
        logic [15:0]        lfsr;
    } t_state;

    // One shift of the right-shifting Galois LFSR.
    function automatic logic [15:0] lfsr_next(input logic [15:0] cur);
        logic [15:0] shifted;
        shifted = {1'b0, cur[15:1]};
        return cur[0] ? (shifted ^ LFSR_TAPS) : shifted;
    endfunction

    // Remainder modulo 255 by folding the two bytes together.
    function automatic logic [7:0] mod255(input logic [15:0] x);
        logic [8:0] s1;
        logic [8:0] s2;
        logic [8:0] s3;
        s1 = {1'b0, x[15:8]} + {1'b0, x[7:0]};
        s2 = {1'b0, s1[7:0]} + {8'b0, s1[8]};
        s3 = s2 - 9'd255;
        return (s2 >= 9'd255) ? s3[7:0] : s2[7:0];
    endfunction

    // Triangle fold of a phase into a duty, fraction bit dropped.
    function automatic logic [7:0] fold_duty(input logic [PHASE_W-1:0] h);
        logic [PHASE_W-1:0] diff;
        diff = PHASE_WRAP - h;
        return (h <= PHASE_HALF) ? h[8:1] : diff[8:1];
    endfunction

    // Phase advance; reaching the wrap point restarts at zero.
    function automatic logic [PHASE_W-1:0] advance_phase(input logic [PHASE_W-1:0] h,
                                                         input logic [8:0] step);
        logic [PHASE_W:0] sum;
        sum = {1'b0, h} + {{(PHASE_W-8){1'b0}}, step};
        return (sum >= {1'b0, PHASE_WRAP}) ? '0 : sum[PHASE_W-1:0];
    endfunction

endpackage

[rtl/lbmc_step.sv]
// ---------------------------------------------------------------------------
// LED breathing mode controller: tick step logic
// Computes the state after one tick from the current state and touch sample.
// ---------------------------------------------------------------------------
module lbmc_step
    import lbmc_pkg::*;
(
    input  t_state     i_state,
    input  logic [9:0] i_touch_sample,
    input  logic [9:0] i_threshold,
    output t_state     o_state
);

    logic [15:0] lfsr_a;
    logic [15:0] lfsr_b;
    logic [8:0]  step;
    t_state      act;

    assign lfsr_a = lfsr_next(i_state.lfsr);
    assign lfsr_b = lfsr_next(lfsr_a);
    assign step   = MODE_STEP[i_state.mode];

    // Mode action: fix bad mode, flicker draws, or selected-channel triangles.
    always_comb begin
        act = i_state;
        if (i_state.mode == 4'd0 || i_state.mode > MODE_LAST) begin
            act.mode = MODE_FIRST;
        end else if (i_state.mode == MODE_FLICKER) begin
            act.lfsr         = lfsr_b;
            act.orange_level = mod255(lfsr_a);
            act.blue_level   = mod255(lfsr_b);
        end else begin
            if (i_state.init_pending) begin
                act.init_pending = 1'b0;
                act.blue_phase   = '0;
                act.orange_phase = '0;
                act.blue_level   = '0;
                act.orange_level = '0;
            end
            if (MODE_BLUE[i_state.mode]) begin
                act.blue_level = fold_duty(act.blue_phase);
                act.blue_phase = advance_phase(act.blue_phase, step);
            end
            if (MODE_ORANGE[i_state.mode]) begin
                act.orange_level = fold_duty(act.orange_phase);
                act.orange_phase = advance_phase(act.orange_phase, step);
            end
        end
    end

    // Touch handling: restart the phases and move to the next mode.
    always_comb begin
        o_state = act;
        if (i_touch_sample > i_threshold) begin
            o_state.init_pending = 1'b1;
            o_state.blue_phase   = '0;
            o_state.orange_phase = '0;
            o_state.mode         = (act.mode >= MODE_LAST) ? MODE_FIRST : act.mode + 4'd1;
        end
    end

endmodule

[rtl/led_breathing_mode_controller.sv]
// ---------------------------------------------------------------------------
// LED breathing mode controller
// Two-channel LED duty generator with twelve breathing and flicker modes.
// ---------------------------------------------------------------------------
// Every input beat is one tick with a touch sample; every tick returns one
// result beat with the blue and orange duties and the mode after touch
// handling. The block takes one tick per clock cycle while the input side
// is not stalled: a tick sits in the input register, the step logic turns
// it and the mode state into the next state, and the result register holds
// the outcome. A held result stalls the input side only when both registers
// are full. The touch threshold resets to 20; the user must write it only
// while no tick is in flight, which the block itself does not enforce.
`include "led_breathing_mode_controller_defines.svh"

module led_breathing_mode_controller
    import lbmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [9:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [9:0] i_touch_sample,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_blue_duty,
    output logic [7:0] o_orange_duty,
    output logic [3:0] o_mode_now
);

    logic [9:0] r_threshold;
    logic       r_in_valid;
    logic [9:0] r_touch;
    logic       r_out_valid;
    logic [7:0] r_blue_duty;
    logic [7:0] r_orange_duty;
    logic [3:0] r_mode_now;
    t_state     r_state;
    t_state     n_state;
    logic       out_free;
    logic       move;
    logic       in_take;
    logic       mode_ok;
    logic       phases_ok;

    // Handshake: the result register frees when empty or when its beat leaves.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_touch <= i_touch_sample;
        end
    end

    lbmc_step u_step (
        .i_state        (r_state),
        .i_touch_sample (r_touch),
        .i_threshold    (r_threshold),
        .o_state        (n_state)
    );

    // Mode and phase state advances once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= MODE_FIRST;
            r_state.init_pending <= 1'b1;
            r_state.blue_phase   <= '0;
            r_state.orange_phase <= '0;
            r_state.blue_level   <= '0;
            r_state.orange_level <= '0;
            r_state.lfsr         <= LFSR_SEED;
        end else if (move) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_blue_duty   <= n_state.blue_level;
            r_orange_duty <= n_state.orange_level;
            r_mode_now    <= n_state.mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_blue_duty   = r_blue_duty;
    assign o_orange_duty = r_orange_duty;
    assign o_mode_now    = r_mode_now;

    // Range flags used by the checks below.
    assign mode_ok   = (r_state.mode >= MODE_FIRST) && (r_state.mode <= MODE_LAST);
    assign phases_ok = (r_state.blue_phase < PHASE_WRAP) && (r_state.orange_phase < PHASE_WRAP);

    // Checks on the state and the pipeline control.
    `LBMC_ASSERT_NOW(a_mode_range, i_clk, i_rst_n, 1'b1, mode_ok)
    `LBMC_ASSERT_NOW(a_phase_range, i_clk, i_rst_n, 1'b1, phases_ok)
    `LBMC_ASSERT_NOW(a_lfsr_live, i_clk, i_rst_n, 1'b1, r_state.lfsr != 16'd0)
    `LBMC_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !move, $stable(r_state))
    `LBMC_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, move, r_out_valid && (r_mode_now == r_state.mode))

endmodule
